### src/sfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfa_pkg;

	// Operation codes
	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_CMP   = 4'd4,
		OP_ITOF  = 4'd5,
		OP_FTOIR = 4'd6,
		OP_FTOIT = 4'd7,
		OP_CLR   = 4'd8
	} op_t;

	// Flag bit positions
	localparam int FL_RESERVED = 0;
	localparam int FL_INVALID  = 1;
	localparam int FL_DIVZERO  = 2;
	localparam int FL_OVERFLOW = 3;
	localparam int FL_UNDER    = 4;
	localparam int FL_INEXACT  = 5;
	localparam int FL_W        = 6;

	// Significand and quotient widths
	localparam int MANT_W = 24;
	localparam int QUO_W  = MANT_W + 1;

endpackage

`default_nettype wire

### src/sfa_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: (dividend * 2^MANT_W) / divisor, one quotient bit a cycle.
// The divisor must be normalized (top bit set).
module sfa_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [sfa_pkg::MANT_W-1:0] dividend,
	input  wire logic [sfa_pkg::MANT_W-1:0] divisor,
	output logic                           done,
	output logic [sfa_pkg::QUO_W-1:0]      quo,
	output logic [sfa_pkg::MANT_W-1:0]     rem
);

	localparam int CNT_W = $clog2(sfa_pkg::QUO_W);

	logic [sfa_pkg::MANT_W-1:0] rem_q;
	logic [sfa_pkg::MANT_W-1:0] dvs_q;
	logic [sfa_pkg::QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       first_q;
	logic                       inb_q;
	logic                       done_q;

	logic [sfa_pkg::MANT_W:0]   trial;
	logic [sfa_pkg::MANT_W:0]   diff;
	logic                       ge;

	// Shift in the next numerator bit and test against the divisor
	always_comb begin
		trial = {rem_q, first_q ? inb_q : 1'b0};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	// Advance one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(sfa_pkg::QUO_W - 1));
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= '0;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(sfa_pkg::QUO_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	// Hold the datapath registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend[sfa_pkg::MANT_W-1:1]};
			inb_q <= dividend[0];
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[sfa_pkg::MANT_W-1:0] : trial[sfa_pkg::MANT_W-1:0];
			quo_q <= {quo_q[sfa_pkg::QUO_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

### src/single_float_alu.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// input    in_valid / in_stall  op, operand_a, operand_b
// output   out_valid/ out_stall result, flag_*, sticky_flags
//
// One item at a time. Compare, conversion to integer, clear, divide by zero
// and reserved operands go from decode straight to the output stage; add,
// multiply and itof pass the left normalizer (8 or 1 bit a cycle) and
// rounding; divide first runs the 25-step restoring divider. A waiting
// result sits in the output register while the next item is taken. Reset
// clears the sticky flags.
module single_float_alu (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [3:0]  op,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      result,
	output logic             flag_reserved,
	output logic             flag_invalid,
	output logic             flag_divide_zero,
	output logic             flag_overflow,
	output logic             flag_underflow,
	output logic             flag_inexact,
	output logic [5:0]       sticky_flags
);

	localparam int MW = 50;

	typedef enum logic [2:0] {S_IDLE, S_DECODE, S_DIV, S_NORM, S_ROUND, S_FIN} state_t;

	state_t               state_q;
	logic [3:0]           op_q;
	logic [31:0]          a_q, b_q;
	logic [MW-1:0]        mag_q;
	logic signed [11:0]   exp_q;
	logic                 neg_q;
	logic [5:0]           cnt_q;
	logic [5:0]           fl_q;
	logic [31:0]          res_q;
	logic                 div_start_q;
	logic                 out_valid_q;
	logic [31:0]          result_q;
	logic [5:0]           flags_q;
	logic [5:0]           sticky_q;
	logic [5:0]           out_sticky_q;

	logic                 div_done;
	logic [sfa_pkg::QUO_W-1:0]  div_quo;
	logic [sfa_pkg::MANT_W-1:0] div_rem;

	// Decode signals
	logic [7:0]  ea, eb, mx, sda, sdb;
	logic        za, zb, rsv_a, rsv_b, nega, negb;
	logic [23:0] ma, mb;
	logic [31:0] beff;
	logic [47:0] va, vb, sha, shb;
	logic [47:0] ala, alb;
	logic signed [MW-1:0] ta, tb, tr;
	logic        early, go_div;
	logic [31:0] early_res;
	logic [5:0]  early_fl;
	logic [MW-1:0] init_mag;
	logic signed [11:0] init_exp;
	logic        init_neg;

	// Float-to-integer and compare
	logic [8:0]  fsh;
	logic [24:0] fmask, fm, fmag;
	logic [31:0] fr;
	logic        finx, finv, fspecial;
	logic [31:0] cmp_res;

	// Rounding
	logic [MW:0]        rsum;
	logic               rcarry, rinx;
	logic signed [11:0] re, rbias;
	logic [22:0]        rfrac;

	logic [sfa_pkg::MANT_W:0] rem2;
	logic [1:0]               rbits;

	sfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (ma),
		.divisor  (mb),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// Unpack operands
	always_comb begin
		beff  = b_q ^ {(op_q == sfa_pkg::OP_SUB), 31'b0};
		ea    = a_q[30:23];
		eb    = b_q[30:23];
		za    = a_q[30:0] == '0;
		zb    = b_q[30:0] == '0;
		rsv_a = !za && (ea == 8'd0 || ea == 8'hFF);
		rsv_b = !zb && (eb == 8'd0 || eb == 8'hFF);
		ma    = {!za, a_q[22:0]};
		mb    = {!zb, b_q[22:0]};
		nega  = a_q[31];
		negb  = beff[31];
	end

	// Align and sum for add and subtract
	always_comb begin
		mx  = (ea > eb) ? ea : eb;
		sda = mx - ea;
		sdb = mx - eb;
		va  = {ma, 24'b0};
		vb  = {mb, 24'b0};
		sha = va >> sda;
		shb = vb >> sdb;
		ala = sha | {47'b0, (sha << sda) != va};
		alb = shb | {47'b0, (shb << sdb) != vb};
		ta  = nega ? -$signed({2'b0, ala}) : $signed({2'b0, ala});
		tb  = negb ? -$signed({2'b0, alb}) : $signed({2'b0, alb});
		tr  = ta + tb;
	end

	// Convert float to integer
	always_comb begin
		fsh      = 9'd150 - {1'b0, ea};
		fmag     = {1'b0, ma};
		fmask    = (25'd1 << fsh[4:0]) - 25'd1;
		fm       = fmag;
		fr       = '0;
		finv     = 1'b0;
		fspecial = 1'b0;
		if (ea < 8'd150) begin
			if (fsh > 9'd24)
				fm = '0;
			else if (op_q == sfa_pkg::OP_FTOIT)
				fm = fmag & ~fmask;
			else
				fm = (fmag + {24'b0, fmag[fsh[4:0]]} + (fmask >> 1)) & ~fmask;
			fr = (fsh > 9'd24) ? 32'd0 : {7'b0, fm >> fsh[4:0]};
		end else if (ea >= 8'd158) begin
			if (ea == 8'd158 && a_q[22:0] == '0 && nega)
				fspecial = 1'b1;
			else begin
				fr   = 32'hFFFF_FFFF;
				finv = 1'b1;
			end
		end else begin
			fr = {8'b0, ma} << (ea - 8'd150);
		end
		finx = fm != fmag;
		if (nega && !fspecial)
			fr = 32'd0 - fr;
		if (fspecial)
			fr = 32'h8000_0000;
	end

	// Compare
	always_comb begin
		if (ea > eb)
			cmp_res = nega ? 32'hFFFF_FFFF : 32'd1;
		else if (ea < eb)
			cmp_res = b_q[31] ? 32'd1 : 32'hFFFF_FFFF;
		else if (ma > mb)
			cmp_res = nega ? 32'hFFFF_FFFF : 32'd1;
		else if (ma < mb)
			cmp_res = b_q[31] ? 32'd1 : 32'hFFFF_FFFF;
		else if (nega != b_q[31] && !za)
			cmp_res = nega ? 32'hFFFF_FFFF : 32'd1;
		else
			cmp_res = '0;
	end

	// Select early results or set up the shared datapath
	always_comb begin
		early     = 1'b1;
		go_div    = 1'b0;
		early_res = '0;
		early_fl  = '0;
		init_mag  = '0;
		init_exp  = '0;
		init_neg  = 1'b0;
		if (op_q == sfa_pkg::OP_CLR) begin
			early = 1'b1;
		end else if (op_q <= sfa_pkg::OP_CMP && (rsv_a || rsv_b)) begin
			early_res = 32'hFFFF_FFFF;
			early_fl[sfa_pkg::FL_RESERVED] = 1'b1;
		end else if ((op_q == sfa_pkg::OP_FTOIR || op_q == sfa_pkg::OP_FTOIT) && rsv_a) begin
			early_res = 32'hFFFF_FFFF;
			early_fl[sfa_pkg::FL_RESERVED] = 1'b1;
		end else begin
			case (op_q)
				sfa_pkg::OP_ADD, sfa_pkg::OP_SUB: begin
					if (a_q == beff && za)
						early_res = {a_q[31], 31'b0};
					else begin
						early    = 1'b0;
						init_neg = tr[MW-1];
						init_mag = tr[MW-1] ? -tr : tr;
						init_exp = $signed({4'b0, mx}) - 12'sd151;
					end
				end
				sfa_pkg::OP_MUL: begin
					early    = 1'b0;
					init_neg = nega ^ b_q[31];
					init_mag = {2'b0, {24'b0, ma} * {24'b0, mb}};
					init_exp = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd277;
				end
				sfa_pkg::OP_DIV: begin
					if (za && zb) begin
						early_res = 32'hFFFF_FFFF;
						early_fl[sfa_pkg::FL_INVALID] = 1'b1;
					end else if (zb) begin
						early_res = {nega ^ b_q[31], 31'h7F80_0000};
						early_fl[sfa_pkg::FL_DIVZERO] = 1'b1;
					end else begin
						early    = 1'b0;
						go_div   = 1'b1;
						init_neg = nega ^ b_q[31];
						init_exp = $signed({4'b0, ea}) - $signed({4'b0, eb}) - 12'sd3;
					end
				end
				sfa_pkg::OP_CMP: early_res = cmp_res;
				sfa_pkg::OP_ITOF: begin
					early    = 1'b0;
					init_neg = nega;
					init_mag = nega ? MW'(32'h8000_0000 - {1'b0, a_q[30:0]})
					                : MW'({1'b0, a_q[30:0]});
					init_exp = 12'sd23;
				end
				sfa_pkg::OP_FTOIR, sfa_pkg::OP_FTOIT: begin
					early_res = fr;
					early_fl[sfa_pkg::FL_INVALID] = finv;
					early_fl[sfa_pkg::FL_INEXACT] = finx;
				end
				default: early_res = '0;
			endcase
		end
	end

	// Divider remainder to guard and sticky bits
	always_comb begin
		rem2 = {div_rem, 1'b0};
		if (rem2 > {1'b0, mb})
			rbits = 2'd3;
		else if (rem2 == {1'b0, mb})
			rbits = 2'd2;
		else if (div_rem != '0)
			rbits = 2'd1;
		else
			rbits = 2'd0;
	end

	// Round the normalized magnitude to 24 bits and pack
	always_comb begin
		rsum   = {1'b0, mag_q} + {{MW{1'b0}}, mag_q[26]} + (MW+1)'(26'h1FF_FFFF);
		rcarry = rsum[MW];
		rinx   = mag_q[25:0] != '0;
		rfrac  = rcarry ? 23'd0 : rsum[48:26];
		re     = exp_q + 12'sd26 - $signed({6'b0, cnt_q}) + $signed({11'b0, rcarry});
		rbias  = (re >= 12'sd128) ? re - 12'sd192 + 12'sd127 : re + 12'sd127;
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			sticky_q    <= '0;
		end else begin
			// Pulse the divider start as a divide leaves decode
			div_start_q <= (state_q == S_DECODE) && go_div;
			// Load the output transfer from S_FIN, drop it once taken
			if (state_q == S_FIN && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					if (early)
						state_q <= S_FIN;
					else if (go_div)
						state_q <= S_DIV;
					else
						state_q <= S_NORM;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_NORM;
				end
				S_NORM: begin
					if (mag_q == '0 || mag_q[MW-1])
						state_q <= (mag_q == '0) ? S_FIN : S_ROUND;
				end
				S_ROUND: state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
						if (op_q == sfa_pkg::OP_CLR)
							sticky_q <= '0;
						else
							sticky_q <= sticky_q | fl_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q <= op;
					a_q  <= operand_a;
					b_q  <= operand_b;
				end
			end
			S_DECODE: begin
				res_q <= early_res;
				fl_q  <= early_fl;
				mag_q <= init_mag;
				exp_q <= init_exp;
				neg_q <= init_neg;
				cnt_q <= '0;
			end
			S_DIV: begin
				if (div_done)
					mag_q <= {{(MW - sfa_pkg::QUO_W - 2){1'b0}}, div_quo, rbits};
			end
			S_NORM: begin
				if (mag_q == '0)
					res_q <= {neg_q, 31'b0};
				else if (!mag_q[MW-1]) begin
					if (mag_q[MW-1:MW-8] == '0) begin
						mag_q <= mag_q << 8;
						cnt_q <= cnt_q + 6'd8;
					end else begin
						mag_q <= mag_q << 1;
						cnt_q <= cnt_q + 6'd1;
					end
				end
			end
			S_ROUND: begin
				if (re <= -12'sd127) begin
					res_q <= {neg_q, 31'b0};
					fl_q[sfa_pkg::FL_UNDER]   <= 1'b1;
					fl_q[sfa_pkg::FL_INEXACT] <= 1'b1;
				end else begin
					res_q <= {neg_q, rbias[7:0], rfrac};
					fl_q[sfa_pkg::FL_OVERFLOW] <= re >= 12'sd128;
					fl_q[sfa_pkg::FL_INEXACT]  <= rinx;
				end
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					result_q     <= res_q;
					flags_q      <= fl_q;
					out_sticky_q <= (op_q == sfa_pkg::OP_CLR) ? '0 : (sticky_q | fl_q);
				end
			end
			default: ;
		endcase
	end

	assign in_stall         = state_q != S_IDLE;
	assign out_valid        = out_valid_q;
	assign result           = result_q;
	assign flag_reserved    = flags_q[sfa_pkg::FL_RESERVED];
	assign flag_invalid     = flags_q[sfa_pkg::FL_INVALID];
	assign flag_divide_zero = flags_q[sfa_pkg::FL_DIVZERO];
	assign flag_overflow    = flags_q[sfa_pkg::FL_OVERFLOW];
	assign flag_underflow   = flags_q[sfa_pkg::FL_UNDER];
	assign flag_inexact     = flags_q[sfa_pkg::FL_INEXACT];
	assign sticky_flags     = out_sticky_q;

endmodule

`default_nettype wire
